// ----- src/path_perceptron_branch_predictor_defines.svh -----
// assertion macros for the branch predictor
`ifndef PATH_PERCEPTRON_BRANCH_PREDICTOR_DEFINES_SVH
`define PATH_PERCEPTRON_BRANCH_PREDICTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define PPBP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PPBP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PPBP_ASSERT_IMP(lbl, ante, cons, msg)
`define PPBP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/ppbp_pkg.sv -----
package ppbp_pkg;

	localparam int TABLE_COUNT    = 16;
	localparam int HISTORY_LENGTH = 17;
	localparam int PATH_VALUES    = 16;
	localparam int WEIGHT_BITS    = 7;

	localparam int ADDR_W     = 4;
	localparam int SUM_W      = 12;
	localparam int THR_W      = 12;
	localparam int UPPER_W    = 6;
	localparam int LOWER_W    = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam int TBL_W  = $clog2(TABLE_COUNT);
	localparam int PATH_W = $clog2(PATH_VALUES);
	localparam int ROWS   = TABLE_COUNT * PATH_VALUES;
	localparam int ROW_W  = $clog2(ROWS);

	// adder tree: bias plus one term per history position, groups of eight
	localparam int GRP     = 8;
	localparam int TERMS   = HISTORY_LENGTH + 1;
	localparam int NGRP    = (TERMS + GRP - 1) / GRP;
	localparam int TERM_W  = WEIGHT_BITS + 1;
	localparam int PART_W  = TERM_W + $clog2(GRP);
	localparam int ACC_RAW = PART_W + $clog2(NGRP) + 1;
	localparam int ACC_W   = (ACC_RAW > SUM_W + 1) ? ACC_RAW : SUM_W + 1;

	localparam int LIM_W = ((WEIGHT_BITS > LOWER_W) ? WEIGHT_BITS : LOWER_W) + 2;
	localparam int WMAX  = 2 ** (WEIGHT_BITS - 1) - 1;
	localparam int WMIN  = -(2 ** (WEIGHT_BITS - 1));

	localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 3'd3;

	typedef logic signed [WEIGHT_BITS-1:0] weight_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic signed [THR_W-1:0]   thr_hi;
		logic signed [THR_W-1:0]   thr_lo;
		logic [UPPER_W-1:0]        upper;
		logic signed [LOWER_W-1:0] lower;
	} cfg_t;

	typedef struct packed {
		logic             load;
		logic             part;
		logic             total;
		logic             update;
		logic             clear;
		logic [ROW_W-1:0] clr_row;
	} cmd_t;

	function automatic logic [TBL_W-1:0] tbl_of(input logic [ADDR_W-1:0] a);
		int r;
		r = int'(a);
		for (int k = 0; k < 8; k++) begin
			if (r >= TABLE_COUNT) begin
				r = r - TABLE_COUNT;
			end
		end
		return TBL_W'(r);
	endfunction

	function automatic logic [PATH_W-1:0] path_of(input logic [ADDR_W-1:0] a);
		int r;
		r = int'(a);
		for (int k = 0; k < 8; k++) begin
			if (r >= PATH_VALUES) begin
				r = r - PATH_VALUES;
			end
		end
		return PATH_W'(r);
	endfunction

	// step by one toward the outcome, saturating at the clamped limits
	function automatic weight_t nudge(input weight_t w, input logic up,
			input weight_t hi, input weight_t lo);
		logic signed [WEIGHT_BITS:0] wx;
		logic signed [WEIGHT_BITS:0] hx;
		logic signed [WEIGHT_BITS:0] lx;
		logic signed [WEIGHT_BITS:0] r;
		wx = (WEIGHT_BITS + 1)'(w);
		hx = (WEIGHT_BITS + 1)'(hi);
		lx = (WEIGHT_BITS + 1)'(lo);
		if (up) begin
			r = wx + (WEIGHT_BITS + 1)'(1);
			if (!(r < hx)) begin
				r = hx;
			end
		end else begin
			r = wx - (WEIGHT_BITS + 1)'(1);
			if (!(r > lx)) begin
				r = lx;
			end
		end
		return r[WEIGHT_BITS-1:0];
	endfunction

endpackage

// ----- src/ppbp_if.sv -----
interface ppbp_in_if;
	import ppbp_pkg::*;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] branch_address;
	logic              taken;
	modport source(output valid, branch_address, taken, input ready);
	modport sink(input valid, branch_address, taken, output ready);
endinterface

interface ppbp_out_if;
	import ppbp_pkg::*;
	logic       valid;
	logic       ready;
	logic       predicted_taken;
	sum_t       perceptron_sum;
	logic       did_train;
	modport source(output valid, predicted_taken, perceptron_sum, did_train, input ready);
	modport sink(input valid, predicted_taken, perceptron_sum, did_train, output ready);
endinterface

interface ppbp_cfg_if;
	import ppbp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- src/ppbp_cfg.sv -----
module ppbp_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid,
	output logic                            ready,
	input  logic [ppbp_pkg::CFG_IDX_W-1:0]  index,
	input  logic [ppbp_pkg::CFG_DATA_W-1:0] data,
	output ppbp_pkg::cfg_t                  regs
);
	import ppbp_pkg::*;

	cfg_t regs_q;

	assign ready = 1'b1;
	assign regs  = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.thr_hi <= THR_W'(47);
			regs_q.thr_lo <= THR_W'(-47);
			regs_q.upper  <= UPPER_W'(63);
			regs_q.lower  <= LOWER_W'(-64);
		end else if (valid) begin
			unique case (index)
				CFG_THR_HIGH:    regs_q.thr_hi <= data[THR_W-1:0];
				CFG_THR_LOW:     regs_q.thr_lo <= data[THR_W-1:0];
				CFG_UPPER_LIMIT: regs_q.upper  <= data[UPPER_W-1:0];
				CFG_LOWER_LIMIT: regs_q.lower  <= data[LOWER_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- src/ppbp_ctrl.sv -----
module ppbp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           branch_valid,
	output logic           branch_ready,
	output logic           result_valid,
	input  logic           result_ready,
	output ppbp_pkg::cmd_t cmd
);
	import ppbp_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ACC   = 3'd2;
	localparam logic [2:0] ST_SUM   = 3'd3;
	localparam logic [2:0] ST_UPD   = 3'd4;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [ROW_W-1:0] clr_q;
	logic             out_valid_q;
	logic             upd_go;

	assign upd_go       = (state_q == ST_UPD) && (!out_valid_q || result_ready);
	assign branch_ready = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		cmd.load    = (state_q == ST_IDLE) && branch_valid;
		cmd.part    = (state_q == ST_ACC);
		cmd.total   = (state_q == ST_SUM);
		cmd.update  = upd_go;
		cmd.clear   = (state_q == ST_CLEAR);
		cmd.clr_row = clr_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == ROW_W'(ROWS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (branch_valid) state_d = ST_ACC;
			end
			ST_ACC:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_UPD;
			ST_UPD: begin
				if (upd_go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + ROW_W'(1);
			if (upd_go) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/ppbp_dp.sv -----
module ppbp_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ppbp_pkg::cmd_t              cmd,
	input  ppbp_pkg::cfg_t              regs,
	input  logic [ppbp_pkg::ADDR_W-1:0] branch_address,
	input  logic                        taken,
	output logic                        predicted_taken,
	output ppbp_pkg::sum_t              perceptron_sum,
	output logic                        did_train
);
	import ppbp_pkg::*;

	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [PART_W-1:0] part_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [LIM_W-1:0]  lim_t;

	localparam acc_t SAT_HI  = ACC_W'(2 ** (SUM_W - 1) - 1);
	localparam acc_t SAT_LO  = ACC_W'(-(2 ** (SUM_W - 1)));
	localparam lim_t WMAX_L  = LIM_W'(WMAX);
	localparam lim_t WMIN_L  = LIM_W'(WMIN);

	// architectural state
	weight_t             bias_q [TABLE_COUNT];
	logic [HISTORY_LENGTH-1:0] hist_q;
	logic [PATH_W-1:0]   path_q [HISTORY_LENGTH];

	// stage 1: bank reads
	logic [TBL_W-1:0]    tbl_in;
	logic [ROW_W-1:0]    row_rd [HISTORY_LENGTH];
	logic [TBL_W-1:0]    tbl_s1;
	logic                taken_s1;
	logic [PATH_W-1:0]   path_new_s1;
	logic [ROW_W-1:0]    row_s1 [HISTORY_LENGTH];
	weight_t             w_s1 [HISTORY_LENGTH];
	weight_t             bias_s1;

	// stage 2 and 3: tree
	term_t               terms [TERMS];
	part_t               part_c [NGRP];
	part_t               part_s2 [NGRP];
	acc_t                acc_c;
	sum_t                sum_c;
	logic                pred_c;
	logic                train_c;
	sum_t                sum_s3;
	logic                pred_s3;
	logic                train_s3;

	// write-back
	lim_t                up_x;
	lim_t                lo_x;
	weight_t             hi_w;
	weight_t             lo_w;
	logic                wr_en;
	logic [ROW_W-1:0]    wr_row [HISTORY_LENGTH];
	weight_t             wr_data [HISTORY_LENGTH];

	// output register
	logic                pred_q;
	sum_t                sum_q;
	logic                train_q;

	assign tbl_in = tbl_of(branch_address);

	always_comb begin
		for (int i = 0; i < HISTORY_LENGTH; i++) begin
			row_rd[i] = ROW_W'(tbl_in) * ROW_W'(PATH_VALUES) + ROW_W'(path_q[i]);
		end
	end

	// limits clamped into the weight range
	always_comb begin
		up_x = lim_t'({{(LIM_W - UPPER_W){1'b0}}, regs.upper});
		lo_x = lim_t'({{(LIM_W - LOWER_W){regs.lower[LOWER_W-1]}}, regs.lower});
		hi_w = (up_x > WMAX_L) ? weight_t'(WMAX) : up_x[WEIGHT_BITS-1:0];
		if (lo_x < WMIN_L) begin
			lo_w = weight_t'(WMIN);
		end else if (lo_x > WMAX_L) begin
			lo_w = weight_t'(WMAX);
		end else begin
			lo_w = lo_x[WEIGHT_BITS-1:0];
		end
	end

	assign wr_en = cmd.clear || (cmd.update && train_s3);

	always_comb begin
		for (int i = 0; i < HISTORY_LENGTH; i++) begin
			wr_row[i]  = cmd.clear ? cmd.clr_row : row_s1[i];
			wr_data[i] = cmd.clear ? weight_t'(0)
				: nudge(w_s1[i], hist_q[i] == taken_s1, hi_w, lo_w);
		end
	end

	// one weight bank per history position
	for (genvar b = 0; b < HISTORY_LENGTH; b++) begin : g_bank
		weight_t mem [ROWS];

		always_ff @(posedge clk) begin
			if (wr_en) mem[wr_row[b]] <= wr_data[b];
			if (cmd.load) w_s1[b] <= mem[row_rd[b]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tbl_s1      <= tbl_in;
			taken_s1    <= taken;
			path_new_s1 <= path_of(branch_address);
			bias_s1     <= bias_q[tbl_in];
			for (int i = 0; i < HISTORY_LENGTH; i++) begin
				row_s1[i] <= row_rd[i];
			end
		end
	end

	always_comb begin
		terms[0] = TERM_W'(bias_s1);
		for (int i = 0; i < HISTORY_LENGTH; i++) begin
			terms[i + 1] = hist_q[i] ? TERM_W'(w_s1[i]) : -TERM_W'(w_s1[i]);
		end
	end

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			part_c[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < TERMS) begin
					part_c[g] = part_c[g] + PART_W'(terms[g * GRP + k]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.part) begin
			for (int g = 0; g < NGRP; g++) begin
				part_s2[g] <= part_c[g];
			end
		end
	end

	always_comb begin
		acc_c = '0;
		for (int g = 0; g < NGRP; g++) begin
			acc_c = acc_c + ACC_W'(part_s2[g]);
		end
		if (acc_c > SAT_HI) begin
			sum_c = SUM_W'(SAT_HI);
		end else if (acc_c < SAT_LO) begin
			sum_c = SUM_W'(SAT_LO);
		end else begin
			sum_c = SUM_W'(acc_c);
		end
		pred_c  = !sum_c[SUM_W-1];
		train_c = (pred_c != taken_s1) || ((sum_c < regs.thr_hi) && (sum_c > regs.thr_lo));
	end

	always_ff @(posedge clk) begin
		if (cmd.total) begin
			sum_s3   <= sum_c;
			pred_s3  <= pred_c;
			train_s3 <= train_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			for (int t = 0; t < TABLE_COUNT; t++) begin
				bias_q[t] <= '0;
			end
			for (int i = 0; i < HISTORY_LENGTH; i++) begin
				path_q[i] <= '0;
			end
		end else if (cmd.update) begin
			if (train_s3) bias_q[tbl_s1] <= nudge(bias_s1, taken_s1, hi_w, lo_w);
			hist_q <= HISTORY_LENGTH'({hist_q, taken_s1});
			for (int i = HISTORY_LENGTH - 1; i >= 1; i--) begin
				path_q[i] <= path_q[i - 1];
			end
			path_q[0] <= path_new_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			pred_q  <= pred_s3;
			sum_q   <= sum_s3;
			train_q <= train_s3;
		end
	end

	assign predicted_taken = pred_q;
	assign perceptron_sum  = sum_q;
	assign did_train       = train_q;

endmodule

// ----- src/path_perceptron_branch_predictor.sv -----
// Path-based perceptron branch predictor. Each transfer on branch carries one resolved branch;
// the block answers with one result on result: the prediction made before training, the
// saturated 12-bit sum, and whether bias and weights were updated. The steps of an item:
// the accept edge reads one weight from each of the history-length banks, then the partial
// sums, the final sum with saturation and the training decision, and the write-back of bias,
// weights, history and path, each get one registered step. The result sits in an output
// register, so the next branch is accepted while it waits; write-back of that next branch
// holds until the earlier result is taken. After reset a clearing pass zeroes the weight
// banks, one row per cycle over all TABLE_COUNT * PATH_VALUES rows (256 by default), while
// branch.ready stays low; configuration writes are taken at any time.
`include "path_perceptron_branch_predictor_defines.svh"

module path_perceptron_branch_predictor (
	input logic        clk,
	input logic        arst_n,
	ppbp_in_if.sink    branch,
	ppbp_out_if.source result,
	ppbp_cfg_if.sink   cfg
);
	import ppbp_pkg::*;

	cmd_t cmd;
	cfg_t regs;
	logic branch_xfer;
	logic pred_ok;

	ppbp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (cfg.valid),
		.ready  (cfg.ready),
		.index  (cfg.index),
		.data   (cfg.data),
		.regs   (regs)
	);

	ppbp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.branch_valid (branch.valid),
		.branch_ready (branch.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd)
	);

	ppbp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.regs            (regs),
		.branch_address  (branch.branch_address),
		.taken           (branch.taken),
		.predicted_taken (result.predicted_taken),
		.perceptron_sum  (result.perceptron_sum),
		.did_train       (result.did_train)
	);

	assign branch_xfer = branch.valid && branch.ready;
	assign pred_ok     = result.predicted_taken == !result.perceptron_sum[SUM_W-1];

	`PPBP_ASSERT_NXT(a_busy_after_accept, branch_xfer, !branch.ready, "branch accepted while busy")
	`PPBP_ASSERT_IMP(a_idle_on_result, $rose(result.valid), branch.ready, "not idle after write-back")
	`PPBP_ASSERT_IMP(a_pred_sign, result.valid, pred_ok, "prediction disagrees with sum sign")

endmodule

// ----- verif/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ppbp_pkg::*;

	localparam int RESET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SUM_MAX       = 2 ** (SUM_W - 1) - 1;
	localparam int SUM_MIN       = -(2 ** (SUM_W - 1));

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic              taken;
	} branch_rec_t;

	typedef struct {
		logic predicted_taken;
		sum_t perceptron_sum;
		logic did_train;
	} prediction_t;

	typedef enum int {ALWAYS_TAKEN, NEVER_TAKEN, PERIODIC, COIN_FLIP} habit_t;

	logic clk = 1'b0;
	logic arst_n;

	ppbp_in_if  branch_if();
	ppbp_out_if result_if();
	ppbp_cfg_if cfg_if();

	path_perceptron_branch_predictor dut (
		.clk(clk),
		.arst_n(arst_n),
		.branch(branch_if),
		.result(result_if),
		.cfg(cfg_if)
	);

	// predictor state
	weight_t                   weight_mem [TABLE_COUNT][PATH_VALUES][HISTORY_LENGTH];
	weight_t                   bias_mem [TABLE_COUNT];
	logic [HISTORY_LENGTH-1:0] outcome_history;
	logic [PATH_W-1:0]         path_addr [HISTORY_LENGTH];
	int                        thr_high;
	int                        thr_low;
	int                        upper_limit;
	int                        lower_limit;

	branch_rec_t branch_queue[$];
	prediction_t expected_predictions[$];

	int   failures    = 0;
	int   cycle_count = 0;
	int   tx_gap      = 0;
	int   rx_stall    = 0;
	bit   tx_idle     = 1'b0;
	bit   rx_idle     = 1'b0;
	logic branch_took = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int clamp_weight(int v);
		if (v > WMAX) return WMAX;
		if (v < WMIN) return WMIN;
		return v;
	endfunction

	function automatic weight_t step_weight(weight_t w, logic up);
		int hi;
		int lo;
		int r;
		hi = clamp_weight(upper_limit);
		lo = clamp_weight(lower_limit);
		if (up) begin
			r = (int'(w) + 1 < hi) ? int'(w) + 1 : hi;
		end else begin
			r = (int'(w) - 1 > lo) ? int'(w) - 1 : lo;
		end
		return weight_t'(clamp_weight(r));
	endfunction

	function automatic prediction_t resolve_branch(branch_rec_t b);
		prediction_t p;
		int          tbl;
		int          acc;
		logic        train;
		tbl = int'(b.addr) % TABLE_COUNT;
		acc = int'(bias_mem[tbl]);
		for (int i = 0; i < HISTORY_LENGTH; i++) begin
			if (outcome_history[i]) begin
				acc += int'(weight_mem[tbl][path_addr[i]][i]);
			end else begin
				acc -= int'(weight_mem[tbl][path_addr[i]][i]);
			end
		end
		if (acc > SUM_MAX) acc = SUM_MAX;
		if (acc < SUM_MIN) acc = SUM_MIN;
		p.predicted_taken = (acc >= 0);
		train = (p.predicted_taken != b.taken) || (acc < thr_high && acc > thr_low);
		if (train) begin
			bias_mem[tbl] = step_weight(bias_mem[tbl], b.taken);
			for (int i = 0; i < HISTORY_LENGTH; i++) begin
				weight_mem[tbl][path_addr[i]][i] =
					step_weight(weight_mem[tbl][path_addr[i]][i], outcome_history[i] == b.taken);
			end
		end
		for (int i = HISTORY_LENGTH - 1; i > 0; i--) begin
			path_addr[i] = path_addr[i-1];
		end
		path_addr[0] = PATH_W'(int'(b.addr) % PATH_VALUES);
		outcome_history = {outcome_history[HISTORY_LENGTH-2:0], b.taken};
		p.perceptron_sum = sum_t'(acc);
		p.did_train = train;
		return p;
	endfunction

	function automatic int draw_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return $urandom_range(1, 2);
		if (roll < 92) return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	// branch driver
	always @(negedge clk) begin : drive_branch
		branch_rec_t next_branch;
		if (!arst_n) begin
			branch_if.valid <= 1'b0;
		end else if (branch_if.valid && !branch_took) begin
			// hold until transfer
		end else if (tx_gap > 0) begin
			branch_if.valid <= 1'b0;
			tx_gap--;
		end else if (branch_queue.size() != 0) begin
			next_branch = branch_queue.pop_front();
			branch_if.valid <= 1'b1;
			branch_if.branch_address <= next_branch.addr;
			branch_if.taken <= next_branch.taken;
			tx_gap = (tx_idle && $urandom_range(0, 2) == 0) ? draw_gap() : 0;
		end else begin
			branch_if.valid <= 1'b0;
		end
	end

	always @(posedge clk) begin : track_branch
		branch_rec_t seen;
		branch_took <= arst_n && branch_if.valid && branch_if.ready;
		if (arst_n && branch_if.valid && branch_if.ready) begin
			seen.addr = branch_if.branch_address;
			seen.taken = branch_if.taken;
			expected_predictions.push_back(resolve_branch(seen));
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (rx_stall > 0) begin
			result_if.ready <= 1'b0;
			rx_stall--;
		end else begin
			result_if.ready <= 1'b1;
			if (rx_idle && $urandom_range(0, 3) == 0) rx_stall = draw_gap();
		end
	end

	always @(posedge clk) begin : check_result
		prediction_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (expected_predictions.size() == 0) begin
				$error("result transfer with no branch outstanding");
				failures++;
			end else begin
				want = expected_predictions.pop_front();
				if (result_if.predicted_taken !== want.predicted_taken) begin
					$error("predicted_taken: expected %0d, got %0d",
						want.predicted_taken, result_if.predicted_taken);
					failures++;
				end
				if (result_if.perceptron_sum !== want.perceptron_sum) begin
					$error("perceptron_sum: expected %0d, got %0d",
						want.perceptron_sum, result_if.perceptron_sum);
					failures++;
				end
				if (result_if.did_train !== want.did_train) begin
					$error("did_train: expected %0d, got %0d",
						want.did_train, result_if.did_train);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic push_branch(logic [ADDR_W-1:0] addr, logic taken);
		branch_rec_t b;
		b.addr = addr;
		b.taken = taken;
		branch_queue.push_back(b);
	endtask

	// mostly short loops of branches with fixed habits, some noise in between
	task automatic queue_branches(int n);
		logic [ADDR_W-1:0] loop_addr [6];
		habit_t            habit [6];
		int                period [6];
		int                len;
		int                reps;
		int                made;
		logic              take;
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 9) < 7) begin
				len = $urandom_range(1, 6);
				reps = $urandom_range(4, 25);
				for (int j = 0; j < len; j++) begin
					loop_addr[j] = ADDR_W'($urandom());
					habit[j] = habit_t'($urandom_range(0, 3));
					period[j] = $urandom_range(2, 5);
				end
				for (int r = 0; r < reps && made < n; r++) begin
					for (int j = 0; j < len && made < n; j++) begin
						case (habit[j])
							ALWAYS_TAKEN: take = 1'b1;
							NEVER_TAKEN:  take = 1'b0;
							PERIODIC:     take = (r % period[j]) != 0;
							default:      take = 1'($urandom());
						endcase
						push_branch(loop_addr[j], take);
						made++;
					end
				end
			end else begin
				repeat ($urandom_range(1, 8)) begin
					push_branch(ADDR_W'($urandom()), 1'($urandom()));
					made++;
				end
			end
		end
	endtask

	task automatic settle();
		while (branch_queue.size() != 0 || branch_if.valid || expected_predictions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			CFG_THR_HIGH:    thr_high = int'(signed'(value));
			CFG_THR_LOW:     thr_low = int'(signed'(value));
			CFG_UPPER_LIMIT: upper_limit = int'(value[UPPER_W-1:0]);
			CFG_LOWER_LIMIT: lower_limit = int'(signed'(value[LOWER_W-1:0]));
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// unused upper data bits get random values
	task automatic set_config(int hi, int lo, int up, int low);
		logic [CFG_DATA_W-1:0] value;
		write_register(CFG_THR_HIGH, CFG_DATA_W'(hi));
		write_register(CFG_THR_LOW, CFG_DATA_W'(lo));
		value = CFG_DATA_W'($urandom());
		value[UPPER_W-1:0] = UPPER_W'(up);
		write_register(CFG_UPPER_LIMIT, value);
		value = CFG_DATA_W'($urandom());
		value[LOWER_W-1:0] = LOWER_W'(low);
		write_register(CFG_LOWER_LIMIT, value);
	endtask

	task automatic run_phase(int n, bit tx, bit rx);
		tx_idle = tx;
		rx_idle = rx;
		queue_branches(n);
		settle();
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		branch_if.valid = 1'b0;
		branch_if.branch_address = '0;
		branch_if.taken = 1'b0;
		result_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		foreach (weight_mem[t, p, h]) weight_mem[t][p][h] = '0;
		foreach (bias_mem[t]) bias_mem[t] = '0;
		foreach (path_addr[h]) path_addr[h] = '0;
		outcome_history = '0;
		thr_high = 47;
		thr_low = -47;
		upper_limit = 63;
		lower_limit = -64;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero sum on a not-taken branch, address extremes, every table once
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		push_branch('0, 1'b0);
		push_branch('0, 1'b1);
		push_branch('1, 1'b1);
		push_branch('1, 1'b0);
		for (int a = 0; a < 2 ** ADDR_W; a++) begin
			push_branch(ADDR_W'(a), 1'(a[0] ^ a[3]));
		end
		repeat (3) push_branch('1, 1'b1);
		settle();

		// always train, widest limits: weights run into saturation
		set_config(SUM_MAX, SUM_MIN, WMAX, WMIN);
		run_phase(300, 1'b0, 1'b0);

		// train on mispredict only, limits pinned at zero
		set_config(SUM_MIN, SUM_MAX, 0, 0);
		run_phase(200, 1'b1, 1'b1);

		// floor above ceiling
		set_config(100, -100, 3, 20);
		run_phase(200, 1'b1, 1'b0);

		set_config(0, 0, 0, 2 ** (LOWER_W - 1) - 1);
		run_phase(150, 1'b0, 1'b1);

		// back to reset values; writes to unmapped indexes must change nothing
		set_config(47, -47, WMAX, WMIN);
		for (int k = int'(CFG_LOWER_LIMIT) + 1; k < 2 ** CFG_IDX_W; k++) begin
			write_register(CFG_IDX_W'(k), CFG_DATA_W'($urandom()));
		end
		run_phase(400, 1'b1, 1'b1);

		repeat (3) begin
			set_config(int'($urandom_range(0, 4095)) - 2048, int'($urandom_range(0, 4095)) - 2048,
				$urandom_range(0, 63), int'($urandom_range(0, 127)) - 64);
			run_phase(150, 1'($urandom()), 1'($urandom()));
		end

		if (failures == 0 && expected_predictions.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- path_perceptron_branch_predictor.f -----
+incdir+src
src/ppbp_pkg.sv
src/ppbp_if.sv
src/ppbp_cfg.sv
src/ppbp_ctrl.sv
src/ppbp_dp.sv
src/path_perceptron_branch_predictor.sv
verif/tb.sv
